>>> design/obstacle_grid_dilation_macros.svh
// Assertion macros used by the checker of the obstacle grid.
// Each macro samples on the rising edge of clock and is switched off during reset.
`ifndef OBSTACLE_GRID_DILATION_MACROS_SVH
`define OBSTACLE_GRID_DILATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OGD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ogd check failed");

// The consequent must hold in the cycle after the antecedent.
`define OGD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ogd check failed");

`endif

>>> design/ogd_pkg.sv
`timescale 1ns / 1ps

package ogd_pkg;

   // Widths fixed by the transaction fields and the registers.
   localparam int COORD_W  = 6;
   localparam int SIDE_W   = 7;
   localparam int RADIUS_W = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 7;
   // Window arithmetic width: a coordinate plus the largest radius still fits.
   localparam int WIN_W = 8;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS      = 2'd2;

   // Request kinds.
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture the request fields
      logic setup;    // register the window bounds and column mask
      logic rd_en;    // read one stored row
      logic rd_scan;  // read at the scan row rather than the request row
      logic step;     // advance the scan row
      logic wr_en;    // write the modified request row back
      logic finish;   // register the result fields
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_grid;
      logic is_query;
      logic scan_last;
   } status_type;

endpackage

>>> design/obstacle_grid_dilation.sv
`timescale 1ns / 1ps
// Query: the clipped window rows (at most 2*radius+1) are read one at a time through the
// single read port of the row store, and the result strobes after the last of them.
// A new transaction is taken only while idle. Write: read, modify, write back of one row.
// Outside the grid: the result comes straight from the setup step. The receiver cannot stall.
// Synchronous reset clears the control state and all row valid bits, and sets the registers to their defaults.

module obstacle_grid_dilation #(
   parameter int MAX_SIDE   = 64,
   parameter int MAX_RADIUS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_type,
   input  logic [ogd_pkg::COORD_W-1:0]    req_cell_x,
   input  logic [ogd_pkg::COORD_W-1:0]    req_cell_y,
   input  logic                           req_mark,
   // Result channel.
   output logic                           rsp_strobe,
   output logic                           rsp_blocked,
   output logic                           rsp_in_grid,
   // Register write channel.
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ogd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ogd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // The controller sequences each transaction; the datapath holds the
   // registers, the row store and the window arithmetic. A query walks the
   // clipped window one row per cycle, ORing the stored rows together, and
   // masks the result with the clipped column span at the end. A write reads
   // the addressed row, changes one bit and writes the row back.

   ogd_pkg::cmd_type    cmd;
   ogd_pkg::status_type status;

   // Registers may be written at any time the block is idle, so the port
   // never holds a write off.
   assign csr_ready = 1'b1;

   ogd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   ogd_datapath #(
      .MAX_SIDE   (MAX_SIDE),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_type    (req_type),
      .req_cell_x  (req_cell_x),
      .req_cell_y  (req_cell_y),
      .req_mark    (req_mark),
      .csr_write   (csr_valid & csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_blocked (rsp_blocked),
      .rsp_in_grid (rsp_in_grid)
   );

endmodule

>>> design/ogd_ctrl.sv
`timescale 1ns / 1ps

module ogd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_strobe,
   output ogd_pkg::cmd_type    cmd,
   input  ogd_pkg::status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_DRAIN,
      ST_MODIFY
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      strobe_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            if (!status.in_grid) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (!status.is_query) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_MODIFY;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_scan = 1'b1;
            cmd.step    = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_MODIFY: begin
            cmd.wr_en  = 1'b1;
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in != ST_IDLE);
         strobe_ff <= cmd.finish;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

>>> design/ogd_datapath.sv
`timescale 1ns / 1ps

module ogd_datapath #(
   parameter int MAX_SIDE   = 64,
   parameter int MAX_RADIUS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ogd_pkg::cmd_type                  cmd,
   output ogd_pkg::status_type               status,
   input  logic                              req_type,
   input  logic [ogd_pkg::COORD_W-1:0]       req_cell_x,
   input  logic [ogd_pkg::COORD_W-1:0]       req_cell_y,
   input  logic                              req_mark,
   input  logic                              csr_write,
   input  logic [ogd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ogd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                              rsp_blocked,
   output logic                              rsp_in_grid
);

   localparam int AW = $clog2(MAX_SIDE);

   // Configuration registers.
   logic [ogd_pkg::SIDE_W-1:0]   grid_width_ff;
   logic [ogd_pkg::SIDE_W-1:0]   grid_height_ff;
   logic [ogd_pkg::RADIUS_W-1:0] radius_ff;

   // Captured request.
   logic                        type_ff;
   logic [ogd_pkg::COORD_W-1:0] x_ff;
   logic [ogd_pkg::COORD_W-1:0] y_ff;
   logic                        mark_ff;

   // Window and scan state.
   logic [ogd_pkg::COORD_W-1:0] y1_ff;
   logic [ogd_pkg::COORD_W-1:0] row_ff;
   logic [MAX_SIDE-1:0]         cols_ff;
   logic [MAX_SIDE-1:0]         acc_ff;
   logic                        scan_pend_ff;

   // Row store with one valid bit per row; an unwritten row reads as zero.
   logic [MAX_SIDE-1:0] mem [MAX_SIDE];
   logic [MAX_SIDE-1:0] row_valid_ff;
   logic [MAX_SIDE-1:0] rd_data_ff;
   logic                rd_valid_ff;

   logic                blocked_ff;
   logic                in_grid_ff;

   logic [ogd_pkg::SIDE_W-1:0] gw_eff;
   logic [ogd_pkg::SIDE_W-1:0] gh_eff;
   logic [ogd_pkg::WIN_W-1:0]  r_ext;
   logic [ogd_pkg::WIN_W-1:0]  x_ext;
   logic [ogd_pkg::WIN_W-1:0]  y_ext;
   logic [ogd_pkg::WIN_W-1:0]  x_hi;
   logic [ogd_pkg::WIN_W-1:0]  y_hi;
   logic [ogd_pkg::COORD_W-1:0] x0;
   logic [ogd_pkg::COORD_W-1:0] x1;
   logic [ogd_pkg::COORD_W-1:0] y0;
   logic [ogd_pkg::COORD_W-1:0] y1;
   logic [MAX_SIDE-1:0]         cols;
   logic                        cell_in_grid;
   logic [MAX_SIDE-1:0]         row_data;
   logic [MAX_SIDE-1:0]         new_row;
   logic [AW-1:0]               rd_addr;
   logic                        blocked_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= ogd_pkg::SIDE_W'(64);
         grid_height_ff <= ogd_pkg::SIDE_W'(64);
         radius_ff      <= '0;
      end else if (csr_write) begin
         case (csr_index)
            ogd_pkg::CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata;
            ogd_pkg::CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata;
            ogd_pkg::CSR_RADIUS:      radius_ff      <= csr_wdata[ogd_pkg::RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   // Sizes of zero act as one, and sizes beyond the store are clamped to it.
   assign gw_eff = (grid_width_ff == '0) ? ogd_pkg::SIDE_W'(1) :
                   (grid_width_ff > ogd_pkg::SIDE_W'(MAX_SIDE)) ?
                   ogd_pkg::SIDE_W'(MAX_SIDE) : grid_width_ff;
   assign gh_eff = (grid_height_ff == '0) ? ogd_pkg::SIDE_W'(1) :
                   (grid_height_ff > ogd_pkg::SIDE_W'(MAX_SIDE)) ?
                   ogd_pkg::SIDE_W'(MAX_SIDE) : grid_height_ff;
   assign r_ext  = (int'(radius_ff) > MAX_RADIUS) ? ogd_pkg::WIN_W'(MAX_RADIUS) :
                   ogd_pkg::WIN_W'(radius_ff);

   assign cell_in_grid = (ogd_pkg::SIDE_W'(x_ff) < gw_eff) &&
                         (ogd_pkg::SIDE_W'(y_ff) < gh_eff);

   assign x_ext = ogd_pkg::WIN_W'(x_ff);
   assign y_ext = ogd_pkg::WIN_W'(y_ff);
   assign x_hi  = x_ext + r_ext;
   assign y_hi  = y_ext + r_ext;
   assign x0 = (x_ext >= r_ext) ? ogd_pkg::COORD_W'(x_ext - r_ext) : '0;
   assign y0 = (y_ext >= r_ext) ? ogd_pkg::COORD_W'(y_ext - r_ext) : '0;
   assign x1 = (x_hi < ogd_pkg::WIN_W'(gw_eff)) ? ogd_pkg::COORD_W'(x_hi) :
               ogd_pkg::COORD_W'(gw_eff - 1'b1);
   assign y1 = (y_hi < ogd_pkg::WIN_W'(gh_eff)) ? ogd_pkg::COORD_W'(y_hi) :
               ogd_pkg::COORD_W'(gh_eff - 1'b1);

   always_comb begin
      for (int i = 0; i < MAX_SIDE; i++) begin
         cols[i] = (i >= int'(x0)) && (i <= int'(x1));
      end
   end

   assign row_data = rd_valid_ff ? rd_data_ff : '0;
   assign rd_addr  = cmd.rd_scan ? row_ff[AW-1:0] : y_ff[AW-1:0];

   always_comb begin
      new_row               = row_data;
      new_row[x_ff[AW-1:0]] = mark_ff;
   end

   // The last scanned row is still in the read register when the result is taken.
   assign blocked_in = (type_ff == ogd_pkg::REQ_QUERY) && cell_in_grid &&
                       (|((acc_ff | (scan_pend_ff ? row_data : '0)) & cols_ff));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_type;
         x_ff    <= req_cell_x;
         y_ff    <= req_cell_y;
         mark_ff <= req_mark;
      end
      if (cmd.setup) begin
         y1_ff   <= y1;
         cols_ff <= cols;
         row_ff  <= y0;
      end else if (cmd.step) begin
         row_ff <= row_ff + 1'b1;
      end
      if (cmd.setup) begin
         acc_ff <= '0;
      end else if (scan_pend_ff) begin
         acc_ff <= acc_ff | row_data;
      end
      if (cmd.finish) begin
         blocked_ff <= blocked_in;
         in_grid_ff <= cell_in_grid;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (cmd.wr_en) begin
         mem[y_ff[AW-1:0]] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         scan_pend_ff <= 1'b0;
      end else begin
         if (cmd.rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
         if (cmd.wr_en) begin
            row_valid_ff[y_ff[AW-1:0]] <= 1'b1;
         end
         scan_pend_ff <= cmd.rd_en & cmd.rd_scan;
      end
   end

   assign status.in_grid   = cell_in_grid;
   assign status.is_query  = (type_ff == ogd_pkg::REQ_QUERY);
   assign status.scan_last = (row_ff == y1_ff);

   assign rsp_blocked = blocked_ff;
   assign rsp_in_grid = in_grid_ff;

endmodule

>>> design/ogd_checker.sv
`timescale 1ns / 1ps
`include "obstacle_grid_dilation_macros.svh"

module ogd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_strobe,
   input logic                           rsp_blocked,
   input logic                           rsp_in_grid
);

   // An accepted transaction always shows the block busy in the cycle after it is taken.
   `OGD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   // A result is only shown once its transaction has left the block.
   `OGD_ASSERT_NOW(a_strobe_idle, rsp_strobe, !busy)
   // A cell outside the grid is never reported as blocked.
   `OGD_ASSERT_NOW(a_outside_clear, rsp_strobe && !rsp_in_grid, !rsp_blocked)
   // Every transaction passes the setup state, so results never come back to back.
   `OGD_ASSERT_NEXT(a_strobe_gap, rsp_strobe, !rsp_strobe)

endmodule

bind obstacle_grid_dilation ogd_checker u_checker (.*);
